FILE: design/mct_pkg.sv
// shared types, constants and helpers for the macd crossover position tracker
// no dependencies; every other design file refers to this package by scoped names
package mct_pkg;

    localparam int PRICE_W        = 32;
    localparam int GUARD_BITS_DEF = 8;
    localparam int LIMIT_W        = 10;
    localparam int HELD_W         = 11;
    localparam int BAL_W          = 48;
    localparam int ACTION_W       = 2;

    // smoothing factors, unsigned q0.16
    localparam int ALPHA_FRAC = 16;
    localparam logic [15:0] ALPHA_SHORT  = 16'd10082;  // 2/13
    localparam logic [15:0] ALPHA_LONG   = 16'd4855;   // 2/27
    localparam logic [15:0] ALPHA_SIGNAL = 16'd13107;  // 2/10

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd1;

    localparam logic [ACTION_W-1:0] ACT_HOLD = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_BUY  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_SELL = 2'd2;

    localparam logic signed [BAL_W-1:0] BAL_MAX = {1'b0, {(BAL_W-1){1'b1}}};
    localparam logic signed [BAL_W-1:0] BAL_MIN = {1'b1, {(BAL_W-1){1'b0}}};

    typedef logic signed [BAL_W-1:0]  t_bal;
    typedef logic signed [HELD_W-1:0] t_held;

    typedef struct packed {
        logic first;
        logic last;
    } t_tag;

    // clamp a sum that grew by one bit back to the balance range
    function automatic t_bal sat_bal(input logic signed [BAL_W:0] v);
        t_bal res;
        if (v[BAL_W] != v[BAL_W-1]) begin
            res = v[BAL_W] ? BAL_MIN : BAL_MAX;
        end else begin
            res = v[BAL_W-1:0];
        end
        return res;
    endfunction

endpackage

FILE: design/mct_avg_stage.sv
// first pipeline stage: short and long exponential averages of the price
// depends on mct_pkg
module mct_avg_stage #(
    parameter int GUARD_BITS = mct_pkg::GUARD_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [mct_pkg::PRICE_W-1:0]      i_price,
    input  mct_pkg::t_tag                    i_tag,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [mct_pkg::PRICE_W+GUARD_BITS-1:0] o_short,
    output logic [mct_pkg::PRICE_W+GUARD_BITS-1:0] o_long,
    output logic [mct_pkg::PRICE_W-1:0]      o_price,
    output mct_pkg::t_tag                    o_tag
);
    localparam int AVG_W  = mct_pkg::PRICE_W + GUARD_BITS;
    localparam int DIFF_W = AVG_W + 1;
    localparam int PROD_W = DIFF_W + 17;

    logic                        r_valid;
    logic [AVG_W-1:0]            r_short, n_short;
    logic [AVG_W-1:0]            r_long, n_long;
    logic [mct_pkg::PRICE_W-1:0] r_price;
    mct_pkg::t_tag               r_tag;

    logic                        advance;
    logic [AVG_W-1:0]            xs;
    logic signed [DIFF_W-1:0]    d_short, d_long;
    logic signed [PROD_W-1:0]    p_short, p_long;
    logic signed [DIFF_W-1:0]    step_short, step_long;
    logic signed [DIFF_W-1:0]    sum_short, sum_long;

    assign o_ready = !r_valid || i_ready;
    assign advance = i_valid && o_ready;

    always_comb begin
        xs         = AVG_W'(i_price) << GUARD_BITS;
        d_short    = $signed({1'b0, xs}) - $signed({1'b0, r_short});
        d_long     = $signed({1'b0, xs}) - $signed({1'b0, r_long});
        p_short    = d_short * $signed({1'b0, mct_pkg::ALPHA_SHORT});
        p_long     = d_long * $signed({1'b0, mct_pkg::ALPHA_LONG});
        // arithmetic shift, i.e. floor toward minus infinity
        step_short = p_short[mct_pkg::ALPHA_FRAC +: DIFF_W];
        step_long  = p_long[mct_pkg::ALPHA_FRAC +: DIFF_W];
        sum_short  = $signed({1'b0, r_short}) + step_short;
        sum_long   = $signed({1'b0, r_long}) + step_long;
        if (i_tag.first) begin
            n_short = xs;
            n_long  = xs;
        end else begin
            n_short = sum_short[AVG_W-1:0];
            n_long  = sum_long[AVG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_short <= '0;
            r_long  <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (advance) begin
                r_short <= n_short;
                r_long  <= n_long;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_price <= i_price;
            r_tag   <= i_tag;
        end
    end

    assign o_valid = r_valid;
    assign o_short = r_short;
    assign o_long  = r_long;
    assign o_price = r_price;
    assign o_tag   = r_tag;

endmodule

FILE: design/mct_signal_stage.sv
// second pipeline stage: macd line and its signal average
// depends on mct_pkg
module mct_signal_stage #(
    parameter int GUARD_BITS = mct_pkg::GUARD_BITS_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_valid,
    output logic                                       o_ready,
    input  logic [mct_pkg::PRICE_W+GUARD_BITS-1:0]     i_short,
    input  logic [mct_pkg::PRICE_W+GUARD_BITS-1:0]     i_long,
    input  logic [mct_pkg::PRICE_W-1:0]                i_price,
    input  mct_pkg::t_tag                              i_tag,
    output logic                                       o_valid,
    input  logic                                       i_ready,
    output logic signed [mct_pkg::PRICE_W+GUARD_BITS:0] o_macd,
    output logic signed [mct_pkg::PRICE_W+GUARD_BITS:0] o_signal,
    output logic [mct_pkg::PRICE_W-1:0]                o_price,
    output mct_pkg::t_tag                              o_tag
);
    localparam int MACD_W = mct_pkg::PRICE_W + GUARD_BITS + 1;
    localparam int SDIF_W = MACD_W + 1;
    localparam int PROD_W = SDIF_W + 17;

    logic                        r_valid;
    logic signed [MACD_W-1:0]    r_signal, n_signal;
    logic signed [MACD_W-1:0]    r_macd;
    logic [mct_pkg::PRICE_W-1:0] r_price;
    mct_pkg::t_tag               r_tag;

    logic                        advance;
    logic signed [MACD_W-1:0]    macd;
    logic signed [SDIF_W-1:0]    diff, step, sum;
    logic signed [PROD_W-1:0]    prod;

    assign o_ready = !r_valid || i_ready;
    assign advance = i_valid && o_ready;

    always_comb begin
        macd = $signed({1'b0, i_short}) - $signed({1'b0, i_long});
        diff = $signed({macd[MACD_W-1], macd}) - $signed({r_signal[MACD_W-1], r_signal});
        prod = diff * $signed({1'b0, mct_pkg::ALPHA_SIGNAL});
        step = prod[mct_pkg::ALPHA_FRAC +: SDIF_W];
        sum  = $signed({r_signal[MACD_W-1], r_signal}) + step;
        if (i_tag.first) begin
            n_signal = '0;
        end else begin
            n_signal = sum[MACD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_signal <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (advance) begin
                r_signal <= n_signal;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_macd  <= macd;
            r_price <= i_price;
            r_tag   <= i_tag;
        end
    end

    assign o_valid  = r_valid;
    assign o_macd   = r_macd;
    assign o_signal = r_signal;
    assign o_price  = r_price;
    assign o_tag    = r_tag;

endmodule

FILE: design/mct_trade_stage.sv
// third pipeline stage: crossover decision, held units and cash balance
// depends on mct_pkg
module mct_trade_stage #(
    parameter int GUARD_BITS = mct_pkg::GUARD_BITS_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic [mct_pkg::LIMIT_W-1:0]                i_limit,
    input  logic                                       i_valid,
    output logic                                       o_ready,
    input  logic signed [mct_pkg::PRICE_W+GUARD_BITS:0] i_macd,
    input  logic signed [mct_pkg::PRICE_W+GUARD_BITS:0] i_signal,
    input  logic [mct_pkg::PRICE_W-1:0]                i_price,
    input  mct_pkg::t_tag                              i_tag,
    output logic                                       o_valid,
    input  logic                                       i_ready,
    output logic [mct_pkg::ACTION_W-1:0]               o_action,
    output mct_pkg::t_held                             o_held,
    output mct_pkg::t_bal                              o_cash,
    output logic [mct_pkg::PRICE_W-1:0]                o_price,
    output mct_pkg::t_tag                              o_tag
);
    localparam int BW = mct_pkg::BAL_W;

    logic                          r_valid;
    mct_pkg::t_held                r_held, n_held;
    mct_pkg::t_bal                 r_cash, n_cash;
    logic [mct_pkg::ACTION_W-1:0]  r_action, n_action;
    logic [mct_pkg::PRICE_W-1:0]   r_price;
    mct_pkg::t_tag                 r_tag;

    logic                          advance;
    mct_pkg::t_held                held_base, pos_lim, neg_lim;
    mct_pkg::t_bal                 cash_base;
    logic signed [BW:0]            price_x, cash_x;

    assign o_ready = !r_valid || i_ready;
    assign advance = i_valid && o_ready;

    always_comb begin
        // first day starts flat before the decision
        held_base = i_tag.first ? '0 : r_held;
        cash_base = i_tag.first ? '0 : r_cash;
        pos_lim   = $signed({1'b0, i_limit});
        neg_lim   = -pos_lim;
        price_x   = $signed({{(BW + 1 - mct_pkg::PRICE_W){1'b0}}, i_price});
        cash_x    = $signed({cash_base[BW-1], cash_base});
        n_held    = held_base;
        n_cash    = cash_base;
        n_action  = mct_pkg::ACT_HOLD;
        if (i_macd > i_signal && held_base < pos_lim) begin
            n_held   = held_base + mct_pkg::t_held'(1);
            n_cash   = mct_pkg::sat_bal(cash_x - price_x);
            n_action = mct_pkg::ACT_BUY;
        end else if (i_macd < i_signal && held_base > neg_lim) begin
            n_held   = held_base - mct_pkg::t_held'(1);
            n_cash   = mct_pkg::sat_bal(cash_x + price_x);
            n_action = mct_pkg::ACT_SELL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_held  <= '0;
            r_cash  <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (advance) begin
                r_held <= n_held;
                r_cash <= n_cash;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_action <= n_action;
            r_price  <= i_price;
            r_tag    <= i_tag;
        end
    end

    assign o_valid  = r_valid;
    assign o_action = r_action;
    assign o_held   = r_held;
    assign o_cash   = r_cash;
    assign o_price  = r_price;
    assign o_tag    = r_tag;

endmodule

FILE: design/mct_settle_stage.sv
// last pipeline stage and result register: balance settled at the current price
// depends on mct_pkg
module mct_settle_stage (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [mct_pkg::ACTION_W-1:0] i_action,
    input  mct_pkg::t_held               i_held,
    input  mct_pkg::t_bal                i_cash,
    input  logic [mct_pkg::PRICE_W-1:0]  i_price,
    input  mct_pkg::t_tag                i_tag,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [mct_pkg::ACTION_W-1:0] o_action,
    output mct_pkg::t_held               o_held,
    output mct_pkg::t_bal                o_cash,
    output mct_pkg::t_bal                o_settled,
    output logic                         o_last
);
    localparam int BW     = mct_pkg::BAL_W;
    localparam int PROD_W = mct_pkg::HELD_W + mct_pkg::PRICE_W + 1;

    logic                         r_valid;
    logic [mct_pkg::ACTION_W-1:0] r_action;
    mct_pkg::t_held               r_held;
    mct_pkg::t_bal                r_cash;
    mct_pkg::t_bal                r_settled;
    logic                         r_last;

    logic                         advance;
    logic signed [PROD_W-1:0]     worth;
    logic signed [BW:0]           total;

    assign o_ready = !r_valid || i_ready;
    assign advance = i_valid && o_ready;

    always_comb begin
        worth = i_held * $signed({1'b0, i_price});
        total = $signed({i_cash[BW-1], i_cash}) + (BW + 1)'(worth);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_action  <= i_action;
            r_held    <= i_held;
            r_cash    <= i_cash;
            r_settled <= mct_pkg::sat_bal(total);
            r_last    <= i_tag.last;
        end
    end

    assign o_valid   = r_valid;
    assign o_action  = r_action;
    assign o_held    = r_held;
    assign o_cash    = r_cash;
    assign o_settled = r_settled;
    assign o_last    = r_last;

endmodule

FILE: design/macd_crossover_position_tracker.sv
// top level of the macd 12/26/9 crossover position tracker
// depends on mct_pkg, mct_avg_stage, mct_signal_stage, mct_trade_stage, mct_settle_stage
//
// usage
//   input channel (i_valid / o_ready) carries one word per trading day: the q16.16
//   closing price plus first-day and last-day marks. a first-day word seeds both
//   price averages, zeroes the signal and flattens position and cash
//   output channel (o_valid / i_ready) returns one word per input word, in order:
//   action (hold, buy, sell), position, cash balance and the balance settled at
//   that day's price; is_last marks the squared-off result of the last day
//   config channel (i_cfg_valid / o_cfg_ready) writes position_limit; it is always
//   ready and should only be written while no words are in flight
// timing
//   four register stages: price averages, signal average, trade decision, settle.
//   each stage keeps its own recurrence, so one word is accepted every cycle as
//   long as i_ready stays high
// reset and stall
//   synchronous active-low reset empties the pipe, zeroes all averages, position
//   and cash, and sets position_limit to 1. when i_ready is low the stages fill up
//   behind the result register; o_ready drops only once every stage holds a word
module macd_crossover_position_tracker #(
    parameter int GUARD_BITS = mct_pkg::GUARD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // config word
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [mct_pkg::LIMIT_W-1:0]  i_cfg_position_limit,
    // price word
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [mct_pkg::PRICE_W-1:0]  i_close_price,
    input  logic                         i_first_day,
    input  logic                         i_last_day,
    // result word
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [mct_pkg::ACTION_W-1:0] o_action,
    output logic signed [mct_pkg::HELD_W-1:0] o_position,
    output logic signed [mct_pkg::BAL_W-1:0]  o_balance,
    output logic signed [mct_pkg::BAL_W-1:0]  o_settled_balance,
    output logic                         o_is_last
);
    localparam int AVG_W  = mct_pkg::PRICE_W + GUARD_BITS;
    localparam int MACD_W = AVG_W + 1;

    // position limit register; the user must write it only between runs, the block does not enforce this
    logic [mct_pkg::LIMIT_W-1:0] r_position_limit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position_limit <= mct_pkg::LIMIT_RESET;
        end else if (i_cfg_valid) begin
            r_position_limit <= i_cfg_position_limit;
        end
    end

    mct_pkg::t_tag in_tag;
    assign in_tag.first = i_first_day;
    assign in_tag.last  = i_last_day;

    // stage 1 -> 2
    logic                        s1_valid, s2_ready;
    logic [AVG_W-1:0]            s1_short, s1_long;
    logic [mct_pkg::PRICE_W-1:0] s1_price;
    mct_pkg::t_tag               s1_tag;

    // stage 2 -> 3
    logic                        s2_valid, s3_ready;
    logic signed [MACD_W-1:0]    s2_macd, s2_signal;
    logic [mct_pkg::PRICE_W-1:0] s2_price;
    mct_pkg::t_tag               s2_tag;

    // stage 3 -> 4
    logic                         s3_valid, s4_ready;
    logic [mct_pkg::ACTION_W-1:0] s3_action;
    mct_pkg::t_held               s3_held;
    mct_pkg::t_bal                s3_cash;
    logic [mct_pkg::PRICE_W-1:0]  s3_price;
    mct_pkg::t_tag                s3_tag;

    mct_avg_stage #(
        .GUARD_BITS (GUARD_BITS)
    ) u_avg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_price (i_close_price),
        .i_tag   (in_tag),
        .o_valid (s1_valid),
        .i_ready (s2_ready),
        .o_short (s1_short),
        .o_long  (s1_long),
        .o_price (s1_price),
        .o_tag   (s1_tag)
    );

    mct_signal_stage #(
        .GUARD_BITS (GUARD_BITS)
    ) u_signal (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s1_valid),
        .o_ready  (s2_ready),
        .i_short  (s1_short),
        .i_long   (s1_long),
        .i_price  (s1_price),
        .i_tag    (s1_tag),
        .o_valid  (s2_valid),
        .i_ready  (s3_ready),
        .o_macd   (s2_macd),
        .o_signal (s2_signal),
        .o_price  (s2_price),
        .o_tag    (s2_tag)
    );

    mct_trade_stage #(
        .GUARD_BITS (GUARD_BITS)
    ) u_trade (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_limit  (r_position_limit),
        .i_valid  (s2_valid),
        .o_ready  (s3_ready),
        .i_macd   (s2_macd),
        .i_signal (s2_signal),
        .i_price  (s2_price),
        .i_tag    (s2_tag),
        .o_valid  (s3_valid),
        .i_ready  (s4_ready),
        .o_action (s3_action),
        .o_held   (s3_held),
        .o_cash   (s3_cash),
        .o_price  (s3_price),
        .o_tag    (s3_tag)
    );

    // result register
    mct_settle_stage u_settle (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s3_valid),
        .o_ready   (s4_ready),
        .i_action  (s3_action),
        .i_held    (s3_held),
        .i_cash    (s3_cash),
        .i_price   (s3_price),
        .i_tag     (s3_tag),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_action  (o_action),
        .o_held    (o_position),
        .o_cash    (o_balance),
        .o_settled (o_settled_balance),
        .o_last    (o_is_last)
    );

    // nothing comes out of the pipe right after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result valid right after reset");

    // an empty pipe always takes a price word
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!s1_valid && !s2_valid && !s3_valid && !o_valid) |-> o_ready)
        else $error("empty pipe refuses input");

    // flat and idle means nothing to settle
    a_flat_settles_to_cash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_action == mct_pkg::ACT_HOLD && o_position == '0)
        |-> o_settled_balance == o_balance)
        else $error("flat position settles away from cash");

    // a buy never ends at the deepest short, a sell never at the deepest long
    a_trade_direction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s3_valid && (s3_action == mct_pkg::ACT_BUY || s3_action == mct_pkg::ACT_SELL))
        |-> (s3_action == mct_pkg::ACT_BUY ? s3_held != -mct_pkg::t_held'(1023)
                                           : s3_held != mct_pkg::t_held'(1023)))
        else $error("trade ends at impossible position");

    // a stalled result word keeps its position and settled balance
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> $stable(o_position) && $stable(o_settled_balance))
        else $error("stalled result changed");

endmodule
